FILE: rtl/spq_pkg.sv
package spq_pkg;

   localparam int unsigned DepthDefault = 64;
   localparam int unsigned KeyWidth     = 64;
   localparam int unsigned StampWidth   = 32;
   localparam int unsigned FieldWidth   = 16;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_SERVE = 1'b1;

   typedef enum logic [1:0] {
      ST_ADDED  = 2'd0,
      ST_FULL   = 2'd1,
      ST_SERVED = 2'd2,
      ST_EMPTY  = 2'd3
   } rsp_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TOP_TAKE,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_CMP,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start_add;
      logic refuse;
      logic report_empty;
      logic top_rd;
      logic top_take;
      logic up_rd;
      logic up_move;
      logic dn_rd;
      logic dn_move;
      logic put_key;
      logic load_rsp;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic parent_less;
      logic leaf;
      logic child_greater;
      logic rsp_free;
   } dp_stat_type;

   // priority with sign flipped, then inverted stamp, then handle:
   // an unsigned compare of two keys gives serve order
   function automatic logic [KeyWidth-1:0] build_key(
      input logic [FieldWidth-1:0] prio,
      input logic [StampWidth-1:0] stamp,
      input logic [FieldWidth-1:0] id
   );
      return {~prio[FieldWidth-1], prio[FieldWidth-2:0], ~stamp, id};
   endfunction

endpackage

FILE: rtl/spq_if.sv
interface spq_req_if;
   logic                valid;
   logic                ready;
   logic                command;
   logic signed [15:0]  priority_req;
   logic        [15:0]  file_id;

   modport source (output valid, command, priority_req, file_id, input ready);
   modport sink   (input valid, command, priority_req, file_id, output ready);
endinterface

interface spq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] served_id;

   modport source (output valid, status, served_id, input ready);
   modport sink   (input valid, status, served_id, output ready);
endinterface

FILE: rtl/spq_ctrl.sv
module spq_ctrl
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_command,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_ADD) begin
                  if (stat.full) begin
                     cmd.refuse = 1'b1;
                     state_in   = S_RESP;
                  end else begin
                     cmd.start_add = 1'b1;
                     state_in      = S_UP_RD;
                  end
               end else if (stat.empty) begin
                  cmd.report_empty = 1'b1;
                  state_in         = S_RESP;
               end else begin
                  cmd.top_rd = 1'b1;
                  state_in   = S_TOP_TAKE;
               end
            end
         end
         S_TOP_TAKE: begin
            cmd.top_take = 1'b1;
            state_in     = S_DN_RD;
         end
         S_UP_RD: begin
            if (stat.pos_zero) begin
               cmd.put_key = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.up_rd = 1'b1;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.parent_less) begin
               cmd.up_move = 1'b1;
               state_in    = S_UP_RD;
            end else begin
               cmd.put_key = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_DN_RD: begin
            if (stat.leaf) begin
               cmd.put_key = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.dn_rd = 1'b1;
               state_in  = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (stat.child_greater) begin
               cmd.dn_move = 1'b1;
               state_in    = S_DN_RD;
            end else begin
               cmd.put_key = 1'b1;
               state_in    = S_RESP;
            end
         end
         S_RESP: begin
            // hold until the output slot is free
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_resp_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && !stat.rsp_free) |=> (state_ff == S_RESP))
      else $error("response dropped while output slot busy");

   a_take_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TOP_TAKE) |-> $past(cmd.top_rd))
      else $error("top taken without a preceding read");

   a_walk_from_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !stat.full && req_command == CMD_ADD)
      |=> (state_ff == S_UP_RD))
      else $error("add did not start sift-up");
`endif

endmodule

FILE: rtl/spq_datapath.sv
module spq_datapath
   import spq_pkg::*;
#(
   parameter int unsigned DEPTH = DepthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [FieldWidth-1:0] req_priority_req,
   input  logic [FieldWidth-1:0] req_file_id,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [FieldWidth-1:0] rsp_served_id
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned XW = AW + 2;

   logic [KeyWidth-1:0]   mem [DEPTH];

   logic [CW-1:0]         count_ff, count_in;
   logic [StampWidth-1:0] stamp_ff, stamp_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [KeyWidth-1:0]   key_ff, key_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic [FieldWidth-1:0] res_id_ff, res_id_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic [FieldWidth-1:0] rsp_id_ff;
   logic [KeyWidth-1:0]   rd0_ff, rd1_ff;

   logic [XW-1:0]         child_a, child_b, count_x;
   logic                  has_b, pick_b;
   logic [KeyWidth-1:0]   child_key;
   logic [AW-1:0]         child_idx, parent_idx;
   logic [AW-1:0]         rd_addr0, rd_addr1;
   logic                  rd_en, wr_en;
   logic [KeyWidth-1:0]   wr_data;
   logic [StampWidth-1:0] stamp_next;

   assign child_a    = {1'b0, pos_ff, 1'b1};
   assign child_b    = child_a + XW'(1);
   assign count_x    = XW'(count_ff);
   assign has_b      = child_b < count_x;
   assign pick_b     = has_b && (rd1_ff > rd0_ff);
   assign child_key  = pick_b ? rd1_ff : rd0_ff;
   assign child_idx  = pick_b ? child_b[AW-1:0] : child_a[AW-1:0];
   assign parent_idx = (pos_ff - AW'(1)) >> 1;
   assign stamp_next = stamp_ff + StampWidth'(1);

   assign stat.full          = (count_ff == CW'(DEPTH));
   assign stat.empty         = (count_ff == '0);
   assign stat.pos_zero      = (pos_ff == '0);
   assign stat.parent_less   = (rd0_ff < key_ff);
   assign stat.leaf          = (child_a >= count_x);
   assign stat.child_greater = (key_ff < child_key);
   assign stat.rsp_free      = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rd_addr0 = '0;
      rd_addr1 = '0;
      rd_en    = cmd.top_rd || cmd.up_rd || cmd.dn_rd;
      if (cmd.top_rd) begin
         rd_addr1 = AW'(count_ff - CW'(1));
      end else if (cmd.up_rd) begin
         rd_addr0 = parent_idx;
      end else if (cmd.dn_rd) begin
         rd_addr0 = child_a[AW-1:0];
         rd_addr1 = has_b ? child_b[AW-1:0] : child_a[AW-1:0];
      end
   end

   assign wr_en   = cmd.put_key || cmd.up_move || cmd.dn_move;
   assign wr_data = cmd.put_key ? key_ff : (cmd.up_move ? rd0_ff : child_key);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff] <= wr_data;
      end
      if (rd_en) begin
         rd0_ff <= mem[rd_addr0];
         rd1_ff <= mem[rd_addr1];
      end
   end

   always_comb begin
      count_in      = count_ff;
      stamp_in      = stamp_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (cmd.start_add) begin
         stamp_in      = stamp_next;
         key_in        = build_key(req_priority_req, stamp_next, req_file_id);
         pos_in        = count_ff[AW-1:0];
         count_in      = count_ff + CW'(1);
         res_status_in = ST_ADDED;
         res_id_in     = '0;
      end
      if (cmd.refuse) begin
         res_status_in = ST_FULL;
         res_id_in     = '0;
      end
      if (cmd.report_empty) begin
         res_status_in = ST_EMPTY;
         res_id_in     = '0;
      end
      if (cmd.top_take) begin
         // last entry fills the hole at the root
         key_in        = rd1_ff;
         res_id_in     = rd0_ff[FieldWidth-1:0];
         res_status_in = ST_SERVED;
         count_in      = count_ff - CW'(1);
         pos_in        = '0;
      end
      if (cmd.up_move) begin
         pos_in = parent_idx;
      end
      if (cmd.dn_move) begin
         pos_in = child_idx;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_served_id = rsp_id_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.start_add |=> (count_ff == CW'($past(count_ff) + CW'(1))))
      else $error("add did not grow the heap");

   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.top_take |-> (count_ff != '0))
      else $error("serve taken from an empty heap");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwrote a pending transfer");
`endif

endmodule

FILE: rtl/stable_priority_request_queue_unit.sv
// Steps: an add walks up from the new slot, a read state and a compare state per level
// (the compare waits on the registered read), to the root or a parent that is not less;
// a serve reads the last entry, takes the top and walks down the same way to a leaf or a
// node with no greater child. One item at a time: the next is accepted the cycle after the
// result is loaded; it waits in the response state until the output slot is free. A
// refused add or serve on empty goes straight to the response state. Reset empties the heap.
module stable_priority_request_queue_unit
   import spq_pkg::*;
#(
   parameter int unsigned DEPTH = DepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req_chan,
   spq_rsp_if.source  rsp_chan
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   spq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_priority_req (req_chan.priority_req),
      .req_file_id      (req_chan.file_id),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_status       (rsp_chan.status),
      .rsp_served_id    (rsp_chan.served_id)
   );

endmodule
